### rtl/signed_varint_codec_assert.svh
// Assertion helpers shared by the codec modules.
// Both sample on clk_i and stay quiet while rst_ni is low.
`ifndef SIGNED_VARINT_CODEC_ASSERT_SVH
`define SIGNED_VARINT_CODEC_ASSERT_SVH

// Same-cycle implication.
`define SVC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("codec check failed");

// Next-cycle implication.
`define SVC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("codec check failed");

`endif

### rtl/svc_pkg.sv
package svc_pkg;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  localparam logic [30:0] MAG_B0 = 31'h0000003F;
  localparam logic [30:0] MAG_B1 = 31'h00001FC0;
  localparam logic [30:0] MAG_B2 = 31'h000FE000;
  localparam logic [30:0] MAG_B3 = 31'h07F00000;
  localparam logic [30:0] MAG_B4 = 31'h78000000;
  localparam logic [30:0] MAG_MAX = 31'h7FFFFFFF;
  localparam logic [7:0] CONT_BIT = 8'h80;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW = $clog2(QDepth);

  // One unit of work for the back end: either a whole encode (n beats)
  // or a single decode result.
  typedef struct packed {
    logic        enc;
    logic        neg;
    logic [2:0]  n;
    kind_e       kind;
    logic [31:0] data;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Byte k of the encoding, continuation bit not yet applied.
  function automatic logic [7:0] enc_byte(input logic [30:0] mag, input logic neg,
                                          input logic [2:0] k);
    logic [7:0] b;
    b = 8'h00;
    case (k)
      3'd0:    b = {1'b0, neg, mag[5:0]};
      3'd1:    b = {1'b0, mag[12:6]};
      3'd2:    b = {1'b0, mag[19:13]};
      3'd3:    b = {1'b0, mag[26:20]};
      3'd4:    b = {4'b0000, mag[30:27]};
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### rtl/svc_queue.sv
module svc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  svc_pkg::job_t push_job_i,
  input  logic          pop_i,
  output svc_pkg::job_t head_o,
  output svc_pkg::qstat_t stat_o
);
  import svc_pkg::*;

  `include "signed_varint_codec_assert.svh"

  job_t              mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]    cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == (QPtrW+1)'(QDepth));
  assign stat_o.empty = (cnt_q == '0);

  `SVC_ASSERT_IMPL(a_no_push_full, push_i, !stat_o.full)
  `SVC_ASSERT_IMPL(a_no_pop_empty, pop_i, !stat_o.empty)

endmodule

### rtl/svc_front.sv
module svc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            tvalid_i,
  output logic            tready_o,
  input  logic [39:0]     tdata_i,
  input  logic            tuser_i,
  input  svc_pkg::qstat_t qstat_i,
  output logic            push_o,
  output svc_pkg::job_t   push_job_o
);
  import svc_pkg::*;

  `include "signed_varint_codec_assert.svh"

  logic [2:0]  byte_index_q, byte_index_d;
  logic [30:0] accum_q, accum_d;
  logic        neg_q, neg_d;

  logic        accept;
  logic [31:0] value;
  logic [7:0]  in_byte;
  logic [31:0] mag_full;
  logic [30:0] mag;
  logic [2:0]  nbytes;
  logic [30:0] acc_new;
  logic        neg_new;

  assign tready_o = !qstat_i.full;
  assign accept   = tvalid_i && tready_o;
  assign value    = tdata_i[31:0];
  assign in_byte  = tdata_i[39:32];

  // Encode: sign-magnitude with the most negative value clamped.
  always_comb begin
    mag_full = value[31] ? (32'd0 - value) : value;
    mag      = mag_full[31] ? MAG_MAX : mag_full[30:0];
    if ((mag & MAG_B4) != '0) begin
      nbytes = 3'd5;
    end else if ((mag & MAG_B3) != '0) begin
      nbytes = 3'd4;
    end else if ((mag & MAG_B2) != '0) begin
      nbytes = 3'd3;
    end else if ((mag & MAG_B1) != '0) begin
      nbytes = 3'd2;
    end else begin
      nbytes = 3'd1;
    end
  end

  // Decode: merge this byte into the accumulator at its position.
  always_comb begin
    acc_new = accum_q;
    neg_new = neg_q;
    case (byte_index_q)
      3'd0: begin
        acc_new = {25'd0, in_byte[5:0]};
        neg_new = in_byte[6];
      end
      3'd1:    acc_new = accum_q | {18'd0, in_byte[6:0], 6'd0};
      3'd2:    acc_new = accum_q | {11'd0, in_byte[6:0], 13'd0};
      3'd3:    acc_new = accum_q | {4'd0, in_byte[6:0], 20'd0};
      3'd4:    acc_new = accum_q | {in_byte[3:0], 27'd0};
      default: acc_new = accum_q;
    endcase
  end

  always_comb begin
    byte_index_d = byte_index_q;
    accum_d      = accum_q;
    neg_d        = neg_q;
    push_o       = 1'b0;
    push_job_o   = '{enc: 1'b1, neg: value[31], n: nbytes, kind: KIND_BYTE,
                     data: {1'b0, mag}};
    if (accept) begin
      if (tuser_i == OP_ENCODE) begin
        push_o = 1'b1;
      end else if (!in_byte[7]) begin
        push_o = 1'b1;
        push_job_o = '{enc: 1'b0, neg: 1'b0, n: 3'd1, kind: KIND_VALUE,
                       data: neg_new ? (32'd0 - {1'b0, acc_new}) : {1'b0, acc_new}};
        byte_index_d = '0;
        accum_d      = '0;
        neg_d        = 1'b0;
      end else if (byte_index_q == 3'd4) begin
        push_o = 1'b1;
        push_job_o = '{enc: 1'b0, neg: 1'b0, n: 3'd1, kind: KIND_ERROR, data: 32'd0};
        byte_index_d = '0;
        accum_d      = '0;
        neg_d        = 1'b0;
      end else begin
        byte_index_d = byte_index_q + 3'd1;
        accum_d      = acc_new;
        neg_d        = neg_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q <= '0;
      accum_q      <= '0;
      neg_q        <= 1'b0;
    end else begin
      byte_index_q <= byte_index_d;
      accum_q      <= accum_d;
      neg_q        <= neg_d;
    end
  end

  `SVC_ASSERT_IMPL(a_index_range, 1'b1, byte_index_q <= 3'd4)
  `SVC_ASSERT_NEXT(a_enc_keeps_group, accept && (tuser_i == OP_ENCODE),
                   $stable(byte_index_q) && $stable(accum_q))

endmodule

### rtl/svc_back.sv
module svc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  svc_pkg::job_t   head_i,
  input  svc_pkg::qstat_t qstat_i,
  output logic            pop_o,
  output logic            tvalid_o,
  input  logic            tready_i,
  output logic [39:0]     tdata_o,
  output svc_pkg::kind_e  tuser_o,
  output logic            tlast_o
);
  import svc_pkg::*;

  `include "signed_varint_codec_assert.svh"

  logic [2:0]  k_q, k_d;
  logic        valid_q, valid_d;
  logic [7:0]  byte_q, byte_d;
  logic [31:0] value_q, value_d;
  kind_e       kind_q, kind_d;
  logic        last_q, last_d;

  logic load;
  logic last_beat;

  assign last_beat = !head_i.enc || (k_q == (head_i.n - 3'd1));
  assign load      = !qstat_i.empty && (!valid_q || tready_i);
  assign pop_o     = load && last_beat;

  always_comb begin
    k_d     = k_q;
    valid_d = valid_q;
    byte_d  = byte_q;
    value_d = value_q;
    kind_d  = kind_q;
    last_d  = last_q;
    if (load) begin
      valid_d = 1'b1;
      last_d  = last_beat;
      kind_d  = head_i.kind;
      k_d     = last_beat ? 3'd0 : k_q + 3'd1;
      if (head_i.enc) begin
        byte_d  = enc_byte(head_i.data[30:0], head_i.neg, k_q) | (last_beat ? 8'h00 : CONT_BIT);
        value_d = 32'd0;
      end else begin
        byte_d  = 8'h00;
        value_d = head_i.data;
      end
    end else if (tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= '0;
      valid_q <= 1'b0;
    end else begin
      k_q     <= k_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    value_q <= value_d;
    kind_q  <= kind_d;
    last_q  <= last_d;
  end

  assign tvalid_o = valid_q;
  assign tdata_o  = {value_q, byte_q};
  assign tuser_o  = kind_q;
  assign tlast_o  = last_q;

  `SVC_ASSERT_IMPL(a_beat_in_range, load && head_i.enc, k_q < head_i.n)

endmodule

### rtl/signed_varint_codec.sv
// Sign-magnitude varint codec, one stream in and one stream out.
// Input beat: tuser selects encode (0) or decode (1); tdata carries the
// 32-bit signed value in [31:0] and the byte to decode in [39:32].
// Encode gives 1 to 5 byte beats (kind 0), tlast on the final byte.
// Decode takes one byte per beat; a byte with bit 7 clear gives one value
// beat (kind 1), a fifth byte still continuing gives an error beat (kind 2).
// Decode bytes that continue a group give no output beat.
// Output beat: tdata [7:0] byte, [39:8] value; tuser is the kind.
// The input beat is written into the job queue, and the result beat is then
// loaded from the queue head into the output register.
// Throughput: one output beat per cycle from the output register while jobs
// are queued and m_axis_tready stays high; an encode gives one beat per byte
// (up to 5) and a decode result one beat. A two-entry job queue sits between the input
// side and the byte sequencer, so input keeps flowing while output stalls
// until the queue fills; tready then drops until the back end pops an entry.
// Reset clears the decode group, the queue and the output valid flag.
module signed_varint_codec (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [39:0]         s_axis_tdata,  // [31:0] value, [39:32] in_byte
  input  logic                s_axis_tuser,  // [0] operation
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [39:0]         m_axis_tdata,  // [7:0] out_byte, [39:8] out_value
  output svc_pkg::kind_e      m_axis_tuser,  // [1:0] kind
  output logic                m_axis_tlast
);
  import svc_pkg::*;

  logic   push, pop;
  job_t   push_job, head;
  qstat_t qstat;

  svc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tvalid_i   (s_axis_tvalid),
    .tready_o   (s_axis_tready),
    .tdata_i    (s_axis_tdata),
    .tuser_i    (s_axis_tuser),
    .qstat_i    (qstat),
    .push_o     (push),
    .push_job_o (push_job)
  );

  svc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (qstat)
  );

  svc_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .qstat_i  (qstat),
    .pop_o    (pop),
    .tvalid_o (m_axis_tvalid),
    .tready_i (m_axis_tready),
    .tdata_o  (m_axis_tdata),
    .tuser_o  (m_axis_tuser),
    .tlast_o  (m_axis_tlast)
  );

endmodule

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import svc_pkg::*;

  typedef struct {
    logic        op;
    logic [31:0] value;
    logic [7:0]  in_byte;
    bit          wait_idle;  // hold off until every pending output beat is in
    int unsigned gap;
    int unsigned rx_max;
  } codec_item_t;

  typedef struct {
    kind_e       kind;
    logic [7:0]  out_byte;
    logic [31:0] out_value;
    logic        last;
  } codec_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tuser = OP_ENCODE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  kind_e       m_axis_tuser;
  logic        m_axis_tlast;

  signed_varint_codec dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

  codec_item_t in_beats_q[$];
  codec_beat_t out_beats_q[$];
  codec_item_t tx_item;
  codec_beat_t want;

  // decode group tracking
  logic [2:0]  grp_pos = '0;
  logic [30:0] grp_mag = '0;
  logic        grp_neg = 1'b0;

  int unsigned tx_gap = 0;
  int unsigned rx_wait = 0;
  int unsigned rx_max_stall = 0;
  int unsigned n_sent = 0;
  int unsigned n_fail = 0;
  logic        rx_hold = 1'b0;

  int unsigned cur_tx_max = 6;
  int unsigned cur_rx_max = 6;
  bit          drain_next = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Bytes of the varint for v, continuation bits applied; returns the count.
  function automatic int varint_bytes(input logic [31:0] v, output logic [7:0] b [5]);
    logic        neg;
    logic [31:0] mag;
    logic [30:0] m;
    int          n;
    neg = v[31];
    mag = neg ? -v : v;
    if (mag > {1'b0, MAG_MAX}) mag = {1'b0, MAG_MAX};  // most negative clamps
    m = mag[30:0];
    if ((m & MAG_B4) != 0) n = 5;
    else if ((m & MAG_B3) != 0) n = 4;
    else if ((m & MAG_B2) != 0) n = 3;
    else if ((m & MAG_B1) != 0) n = 2;
    else n = 1;
    b[0] = {1'b0, neg, m[5:0]};
    b[1] = {1'b0, m[12:6]};
    b[2] = {1'b0, m[19:13]};
    b[3] = {1'b0, m[26:20]};
    b[4] = {4'b0000, m[30:27]};
    for (int k = 0; k < n - 1; k++) b[k] = b[k] | CONT_BIT;
    return n;
  endfunction

  function automatic void predict_codec_beats(input codec_item_t it);
    logic [7:0]  b [5];
    int          n;
    logic [31:0] val;
    if (it.op == OP_ENCODE) begin
      n = varint_bytes(it.value, b);
      for (int k = 0; k < n; k++)
        out_beats_q.push_back('{kind: KIND_BYTE, out_byte: b[k], out_value: 32'd0,
                                last: (k == n - 1)});
    end else begin
      case (grp_pos)
        3'd0: begin
          grp_mag = {25'd0, it.in_byte[5:0]};
          grp_neg = it.in_byte[6];
        end
        3'd1: grp_mag[12:6] = it.in_byte[6:0];
        3'd2: grp_mag[19:13] = it.in_byte[6:0];
        3'd3: grp_mag[26:20] = it.in_byte[6:0];
        default: grp_mag[30:27] = it.in_byte[3:0];  // bits 6..4 dropped
      endcase
      if ((it.in_byte & CONT_BIT) == 0) begin
        val = grp_neg ? -{1'b0, grp_mag} : {1'b0, grp_mag};
        out_beats_q.push_back('{kind: KIND_VALUE, out_byte: 8'd0, out_value: val, last: 1'b1});
        grp_pos = '0;
        grp_mag = '0;
        grp_neg = 1'b0;
      end else if (grp_pos == 3'd4) begin
        out_beats_q.push_back('{kind: KIND_ERROR, out_byte: 8'd0, out_value: 32'd0,
                                last: 1'b1});
        grp_pos = '0;
        grp_mag = '0;
        grp_neg = 1'b0;
      end else begin
        grp_pos = grp_pos + 3'd1;
      end
    end
  endfunction

  function automatic void add_item(input logic op, input logic [31:0] value,
                                   input logic [7:0] in_byte);
    codec_item_t it;
    it.op = op;
    it.value = (op == OP_ENCODE) ? value : $urandom();
    it.in_byte = (op == OP_DECODE) ? in_byte : 8'($urandom());
    it.wait_idle = drain_next;
    it.gap = $urandom_range(0, cur_tx_max);
    it.rx_max = cur_rx_max;
    drain_next = 1'b0;
    in_beats_q.push_back(it);
  endfunction

  function automatic logic [31:0] rand_value();
    logic [31:0] v;
    int unsigned w;
    w = $urandom_range(0, 32);
    v = (w == 0) ? 32'd0 : ($urandom() >> (32 - w));
    if ($urandom_range(0, 1) == 1) v = -v;
    if ($urandom_range(0, 15) == 0) v = 32'h8000_0000;
    return v;
  endfunction

  function automatic void report_mismatch(input string field, input logic [31:0] exp_v,
                                          input logic [31:0] got_v);
    n_fail++;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_v, got_v);
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= OP_ENCODE;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_codec_beats(tx_item);
        n_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (in_beats_q.size() > 0 &&
                     !(in_beats_q[0].wait_idle && out_beats_q.size() > 0)) begin
          tx_item = in_beats_q.pop_front();
          tx_gap = tx_item.gap;
          rx_max_stall = tx_item.rx_max;
          s_axis_tdata <= {tx_item.in_byte, tx_item.value};
          s_axis_tuser <= tx_item.op;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (out_beats_q.size() == 0) begin
          n_fail++;
          $display("%0t: unexpected beat, expected none, got kind %0d data %0h last %0b",
                   $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end else begin
          want = out_beats_q.pop_front();
          if (m_axis_tuser !== want.kind)
            report_mismatch("kind", 32'(want.kind), 32'(m_axis_tuser));
          if (m_axis_tdata[7:0] !== want.out_byte)
            report_mismatch("out_byte", 32'(want.out_byte), 32'(m_axis_tdata[7:0]));
          if (m_axis_tdata[39:8] !== want.out_value)
            report_mismatch("out_value", want.out_value, m_axis_tdata[39:8]);
          if (m_axis_tlast !== want.last)
            report_mismatch("last", 32'(want.last), 32'(m_axis_tlast));
        end
        rx_wait = $urandom_range(0, rx_max_stall);
      end
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        m_axis_tready <= 1'b0;
        rx_wait--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // long output stall so the job queue fills and the input side backs up
  initial begin
    while (n_sent < 40) @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (80) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [7:0]  b [5];
    int          n;
    int          ins;
    int unsigned r;
    int unsigned phase_start;

    // encode extremes and lengths 1, 2, 3 and 5
    add_item(OP_ENCODE, 32'd0, 8'd0);
    add_item(OP_ENCODE, 32'hFFFF_FFFF, 8'd0);
    add_item(OP_ENCODE, 32'd63, 8'd0);
    add_item(OP_ENCODE, 32'd64, 8'd0);
    add_item(OP_ENCODE, -32'd8192, 8'd0);
    add_item(OP_ENCODE, 32'h7FFF_FFFF, 8'd0);
    add_item(OP_ENCODE, 32'h8000_0000, 8'd0);
    add_item(OP_ENCODE, 32'h8000_0001, 8'd0);
    add_item(OP_ENCODE, 32'h0800_0000, 8'd0);
    // negative zero
    add_item(OP_DECODE, 32'd0, 8'h40);
    // full-length negative group with an encode in the middle; the fifth
    // byte has bits 6..4 set, which must be ignored
    add_item(OP_DECODE, 32'd0, 8'hFF);
    add_item(OP_ENCODE, 32'd127, 8'd0);
    add_item(OP_DECODE, 32'd0, 8'hFF);
    add_item(OP_DECODE, 32'd0, 8'hFF);
    add_item(OP_DECODE, 32'd0, 8'hFF);
    add_item(OP_DECODE, 32'd0, 8'h7F);
    // overlong group
    repeat (5) add_item(OP_DECODE, 32'd0, 8'h80);
    add_item(OP_DECODE, 32'd0, 8'h3F);

    cur_tx_max = 2;
    cur_rx_max = 3;
    drain_next = 1'b1;
    phase_start = in_beats_q.size();
    while (in_beats_q.size() < 320) begin
      if (in_beats_q.size() - phase_start >= 40) begin
        phase_start = in_beats_q.size();
        cur_tx_max = $urandom_range(0, 1) ? 6 : 0;
        cur_rx_max = $urandom_range(0, 1) ? 6 : 0;
        drain_next = $urandom_range(0, 1);
      end
      r = $urandom_range(0, 9);
      if (r <= 3) begin
        add_item(OP_ENCODE, rand_value(), 8'd0);
      end else if (r <= 7) begin
        // well-formed group, sometimes with an encode slipped in
        n = varint_bytes(rand_value(), b);
        ins = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1;
        for (int k = 0; k < n; k++) begin
          if (k == ins) add_item(OP_ENCODE, rand_value(), 8'd0);
          add_item(OP_DECODE, 32'd0, b[k]);
        end
      end else if (r == 8) begin
        // four continuing bytes, then a random fifth
        repeat (4) add_item(OP_DECODE, 32'd0, CONT_BIT | 8'($urandom_range(0, 127)));
        add_item(OP_DECODE, 32'd0, 8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 3)) add_item(OP_DECODE, 32'd0, 8'($urandom_range(0, 255)));
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (in_beats_q.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    while (out_beats_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (n_fail == 0 && out_beats_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
